// ----- src/mdaa_pkg.sv -----
// ----------------------------------------------------------------------------
// mdaa_pkg
// Shared types and constants of the row-major multidimensional array access
// unit: word formats, status codes, register map and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package mdaa_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_DIMS_DEF    = 4;
  localparam int STORE_WORDS_DEF = 4096;

  // Fixed field widths.
  localparam int NUM_INDEX   = 4;   // subscript fields in an input word
  localparam int INDEX_SEL_W = 2;   // bits that select one subscript field
  localparam int IDX_W       = 12;
  localparam int LEN_W       = 13;
  localparam int NDIM_W      = 3;
  localparam int DATA_W      = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DIMS = 4'd0;
  localparam int CFG_LEN_BASE = 1;  // length of dimension d sits at CFG_LEN_BASE + d

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SIZE  = 2'd2
  } status_e;

  // One input word.
  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         index_dim0;
    logic [IDX_W-1:0]         index_dim1;
    logic [IDX_W-1:0]         index_dim2;
    logic [IDX_W-1:0]         index_dim3;
    logic signed [DATA_W-1:0] write_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    status_e                  status;
    logic [IDX_W-1:0]         element_offset;
    logic signed [DATA_W-1:0] read_value;
  } out_word_t;

endpackage

`default_nettype wire

// ----- src/multi_dim_array_access_unit.sv -----
// ----------------------------------------------------------------------------
// multi_dim_array_access_unit
// Row-major N-dimensional array access. One shared multiply-add unit first
// forms the saturated element count, then the flat offset in Horner form,
// one dimension per cycle; the element store is then read or written.
// ----------------------------------------------------------------------------
// Sequence: an accepted word runs the size pass over the N dimensions in use,
//   then the offset pass and the store access; a size error ends either pass,
//   a range error ends the offset pass. A new word is taken only when idle,
//   once the result of the last one is loaded into the result register.
// Reset: control and configuration (one dimension, all lengths 1) are
//   cleared at once; the element store is not cleared and needs no sweep.
`default_nettype none

module multi_dim_array_access_unit #(
  parameter int MAX_DIMS    = mdaa_pkg::MAX_DIMS_DEF,
  parameter int STORE_WORDS = mdaa_pkg::STORE_WORDS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [mdaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mdaa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input word channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire mdaa_pkg::in_word_t              in_word_i,
  // result word channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output mdaa_pkg::out_word_t                  out_word_o
);

  localparam int AW    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int ACC_W = AW + 1;
  localparam int SUM_W = ACC_W + mdaa_pkg::LEN_W + 1;
  localparam int DIM_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W = mdaa_pkg::NDIM_W + 1;

  localparam logic [ACC_W-1:0] SAT_VAL   = ACC_W'(STORE_WORDS + 1);
  localparam logic [SUM_W-1:0] STORE_LIM = SUM_W'(STORE_WORDS);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SIZE   = 5'b00010,
    S_INDEX  = 5'b00100,
    S_ACCESS = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e                           state_q, state_d;
  logic [DIM_W-1:0]                 dim_q, dim_d;
  logic [ACC_W-1:0]                 acc_q, acc_d;
  mdaa_pkg::status_e                st_q, st_d;
  mdaa_pkg::in_word_t               item_q;
  logic [mdaa_pkg::NDIM_W-1:0]      num_dims_q;
  logic [mdaa_pkg::LEN_W-1:0]       len_q [MAX_DIMS];
  logic                             out_valid_q, out_valid_d;
  mdaa_pkg::out_word_t              out_word_q, out_word_d;

  logic                             in_take;
  logic                             cfg_we;
  logic                             out_load;
  logic [CNT_W-1:0]                 used_dims;
  logic [DIM_W-1:0]                 last_dim;
  logic                             at_last;
  logic [mdaa_pkg::LEN_W-1:0]       cur_len;
  logic [3:0]                       dim_wide;
  logic [mdaa_pkg::IDX_W-1:0]       idx_arr [mdaa_pkg::NUM_INDEX];
  logic [mdaa_pkg::IDX_W-1:0]       cur_sub;
  logic [ACC_W+mdaa_pkg::LEN_W-1:0] mac_prod;
  logic [SUM_W-1:0]                 mac_sum;
  logic                             mem_en;
  logic                             mem_we;
  logic [mdaa_pkg::DATA_W-1:0]      mem_rdata;

  // Handshakes.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i & ~in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= mdaa_pkg::NDIM_W'(1);
      for (int d = 0; d < MAX_DIMS; d++) begin
        len_q[d] <= mdaa_pkg::LEN_W'(1);
      end
    end else if (cfg_we) begin
      if (cfg_idx_i == mdaa_pkg::CFG_NUM_DIMS) begin
        num_dims_q <= cfg_data_i[mdaa_pkg::NDIM_W-1:0];
      end
      for (int d = 0; d < MAX_DIMS; d++) begin
        if (cfg_idx_i == mdaa_pkg::CFG_IDX_W'(mdaa_pkg::CFG_LEN_BASE + d)) begin
          len_q[d] <= cfg_data_i[mdaa_pkg::LEN_W-1:0];
        end
      end
    end
  end

  // Dimensions in use: zero counts as one, the count saturates at MAX_DIMS.
  always_comb begin
    if (num_dims_q == '0) begin
      used_dims = CNT_W'(1);
    end else if (CNT_W'(num_dims_q) > CNT_W'(MAX_DIMS)) begin
      used_dims = CNT_W'(MAX_DIMS);
    end else begin
      used_dims = CNT_W'(num_dims_q);
    end
  end
  assign last_dim = DIM_W'(used_dims - CNT_W'(1));
  assign at_last  = (dim_q == last_dim);

  // Subscript of the current dimension; dimensions past the fields use zero.
  assign idx_arr[0] = item_q.index_dim0;
  assign idx_arr[1] = item_q.index_dim1;
  assign idx_arr[2] = item_q.index_dim2;
  assign idx_arr[3] = item_q.index_dim3;
  assign dim_wide   = 4'(dim_q);
  assign cur_sub    = (dim_wide < 4'(mdaa_pkg::NUM_INDEX))
                    ? idx_arr[dim_wide[mdaa_pkg::INDEX_SEL_W-1:0]] : '0;
  assign cur_len    = len_q[dim_q];

  // Shared multiply-add: acc * length (+ subscript in the offset pass).
  assign mac_prod = acc_q * cur_len;
  assign mac_sum  = SUM_W'(mac_prod)
                  + ((state_q == S_INDEX) ? SUM_W'(cur_sub) : '0);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    dim_d   = dim_q;
    acc_d   = acc_q;
    st_d    = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_take) begin
          state_d = S_SIZE;
          dim_d   = '0;
          acc_d   = ACC_W'(1);
          st_d    = mdaa_pkg::ST_OK;
        end
      end
      // Element count, saturated just above the store size.
      S_SIZE: begin
        acc_d = (mac_sum > STORE_LIM) ? SAT_VAL : ACC_W'(mac_sum);
        if (at_last) begin
          dim_d = '0;
          if (mac_sum > STORE_LIM) begin
            st_d    = mdaa_pkg::ST_SIZE;
            state_d = S_DONE;
          end else begin
            acc_d   = '0;
            state_d = S_INDEX;
          end
        end else begin
          dim_d = dim_q + DIM_W'(1);
        end
      end
      // Range check and Horner step of the flat offset.
      S_INDEX: begin
        if (mdaa_pkg::LEN_W'(cur_sub) >= cur_len) begin
          st_d    = mdaa_pkg::ST_RANGE;
          state_d = S_DONE;
        end else begin
          acc_d = ACC_W'(mac_sum);
          if (at_last) begin
            if (mac_sum >= STORE_LIM) begin
              st_d    = mdaa_pkg::ST_SIZE;
              state_d = S_DONE;
            end else begin
              state_d = S_ACCESS;
            end
          end else begin
            dim_d = dim_q + DIM_W'(1);
          end
        end
      end
      S_ACCESS: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dim_q   <= '0;
      acc_q   <= '0;
      st_q    <= mdaa_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      dim_q   <= dim_d;
      acc_q   <= acc_d;
      st_q    <= st_d;
    end
  end

  // Captured input word.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_word_i;
    end
  end

  // Element store access.
  assign mem_en = (state_q == S_ACCESS);
  assign mem_we = mem_en & (item_q.kind == mdaa_pkg::KIND_WRITE);

  mdaa_store #(
    .DEPTH (STORE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (acc_q[AW-1:0]),
    .wdata_i (item_q.write_value),
    .rdata_o (mem_rdata)
  );

  // Result register; loads when empty or being drained.
  assign out_load = (state_q == S_DONE) & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_word_d                = out_word_q;
    if (out_load) begin
      out_word_d.status         = st_q;
      out_word_d.element_offset = '0;
      out_word_d.read_value     = '0;
      if (st_q == mdaa_pkg::ST_OK) begin
        out_word_d.element_offset = mdaa_pkg::IDX_W'(acc_q);
        if (item_q.kind == mdaa_pkg::KIND_READ) begin
          out_word_d.read_value = mem_rdata;
        end
      end
    end
  end
  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // Checks.
  a_take_starts_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q == S_SIZE))
    else $error("accepted word did not start the size pass");

  a_dim_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SIZE) || (state_q == S_INDEX)) |-> (dim_q <= last_dim))
    else $error("dimension counter past the last dimension in use");

  a_access_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS) |-> ((acc_q < ACC_W'(STORE_WORDS)) && (st_q == mdaa_pkg::ST_OK)))
    else $error("store access with an offset outside the store");

  a_error_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status != mdaa_pkg::ST_OK))
      |-> ((out_word_o.element_offset == '0) && (out_word_o.read_value == '0)))
    else $error("error result carries offset or data");

endmodule

`default_nettype wire

// ----- src/mdaa_store.sv -----
// ----------------------------------------------------------------------------
// mdaa_store
// Single-port element store with a registered read port. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module mdaa_store #(
  parameter int DEPTH = mdaa_pkg::STORE_WORDS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               addr_i,
  input  wire logic [mdaa_pkg::DATA_W-1:0] wdata_i,
  output logic      [mdaa_pkg::DATA_W-1:0] rdata_o
);

  logic [mdaa_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [mdaa_pkg::DATA_W-1:0] rdata_q;

  // One access per cycle: a write or a registered read.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
